// ----- sv/hsvbgr_pkg.sv -----
// ----------------------------------------------------------------------------
// hsvbgr_pkg
// shared types and constants for the hsv to bgr pixel converter pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package hsvbgr_pkg;

    // input and output pixels
    typedef struct packed {
        logic signed [15:0] hue_in;
        logic signed [15:0] sat_in;
        logic signed [15:0] val_in;
    } hsv_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } bgr_t;

    // sector codes
    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    // arithmetic constants
    localparam logic [8:0]  SECTOR_SPAN = 9'd85;
    localparam logic [6:0]  SECTOR_M    = 7'd85;
    localparam logic [8:0]  HUE_TOP     = 9'd510;
    localparam logic [14:0] FULL_DEN    = 15'd21675;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;
    localparam logic [9:0]  P_DIV2      = 10'd510;
    localparam logic [15:0] Q_DIV2      = 16'd43350;
    localparam logic [8:0]  P_RECIP     = 9'd257;
    localparam logic [8:0]  Q_RECIP     = 9'd387;

    // after the sector split
    typedef struct packed {
        logic [2:0] sector;
        logic [6:0] m;
        logic [7:0] s;
        logic [7:0] v;
    } split_t;

    // after the saturation products
    typedef struct packed {
        logic [2:0]  sector;
        logic [7:0]  v;
        logic [7:0]  s_inv;
        logic [14:0] sm;
        logic [14:0] st;
    } sprod_t;

    // rounding numerators
    typedef struct packed {
        logic [2:0]  sector;
        logic [7:0]  v;
        logic [16:0] xp;
        logic [23:0] xq;
        logic [23:0] xt;
    } numer_t;

    // quotient estimates
    typedef struct packed {
        logic [2:0]  sector;
        logic [7:0]  v;
        logic [16:0] xp;
        logic [23:0] xq;
        logic [23:0] xt;
        logic [7:0]  ep;
        logic [7:0]  eq;
        logic [7:0]  et;
    } estim_t;

endpackage

`default_nettype wire

// ----- sv/hsvbgr_sector.sv -----
// ----------------------------------------------------------------------------
// hsvbgr_sector
// clamps the inputs to 0..255 and splits hue into sector and remainder
// ----------------------------------------------------------------------------
`default_nettype none

module hsvbgr_sector
    import hsvbgr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   up_valid,
    output logic        up_stall,
    input  wire hsv_t   up_data,
    output logic        dn_valid,
    input  wire logic   dn_stall,
    output split_t      dn_data
);

    logic   valid_reg;
    logic   valid_next;
    split_t data_reg;
    split_t data_next;
    logic   en;
    logic [7:0] h;
    logic [8:0] h2;

    function automatic logic [7:0] clamp8(input logic [15:0] x);
        logic [7:0] r;
        if (x[15])
        begin
            r = 8'd0;
        end
        else if (|x[14:8])
        begin
            r = LEVEL_MAX;
        end
        else
        begin
            r = x[7:0];
        end
        return r;
    endfunction

    assign en       = !valid_reg || !dn_stall;
    assign up_stall = !en;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    assign h          = clamp8(up_data.hue_in);
    assign h2         = {h, 1'b0};
    assign valid_next = up_valid;

    always_comb
    begin
        data_next.s = clamp8(up_data.sat_in);
        data_next.v = clamp8(up_data.val_in);
        // top of the circle wraps to sector 0 with m of 0
        if (h2 == HUE_TOP)
        begin
            data_next.sector = SEC_0;
            data_next.m      = 7'd0;
        end
        else if (h2 >= 9'(5 * SECTOR_SPAN))
        begin
            data_next.sector = SEC_5;
            data_next.m      = 7'(h2 - 9'(5 * SECTOR_SPAN));
        end
        else if (h2 >= 9'(4 * SECTOR_SPAN))
        begin
            data_next.sector = SEC_4;
            data_next.m      = 7'(h2 - 9'(4 * SECTOR_SPAN));
        end
        else if (h2 >= 9'(3 * SECTOR_SPAN))
        begin
            data_next.sector = SEC_3;
            data_next.m      = 7'(h2 - 9'(3 * SECTOR_SPAN));
        end
        else if (h2 >= 9'(2 * SECTOR_SPAN))
        begin
            data_next.sector = SEC_2;
            data_next.m      = 7'(h2 - 9'(2 * SECTOR_SPAN));
        end
        else if (h2 >= SECTOR_SPAN)
        begin
            data_next.sector = SEC_1;
            data_next.m      = 7'(h2 - SECTOR_SPAN);
        end
        else
        begin
            data_next.sector = SEC_0;
            data_next.m      = h2[6:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && up_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hsvbgr_product.sv -----
// ----------------------------------------------------------------------------
// hsvbgr_product
// two stages: saturation products, then value products and rounding bias
// ----------------------------------------------------------------------------
`default_nettype none

module hsvbgr_product
    import hsvbgr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   up_valid,
    output logic        up_stall,
    input  wire split_t up_data,
    output logic        dn_valid,
    input  wire logic   dn_stall,
    output numer_t      dn_data
);

    logic   a_valid_reg;
    logic   a_valid_next;
    sprod_t a_reg;
    sprod_t a_next;
    logic   a_en;
    logic   b_valid_reg;
    logic   b_valid_next;
    numer_t b_reg;
    numer_t b_next;
    logic   b_en;
    logic [6:0]  em;
    logic [14:0] qd;
    logic [14:0] td;
    logic [22:0] qn;
    logic [22:0] tn;
    logic [15:0] pn;

    // stage a: s*m, s*(85-m), 255-s
    assign b_en     = !b_valid_reg || !dn_stall;
    assign a_en     = !a_valid_reg || b_en;
    assign up_stall = !a_en;
    assign dn_valid = b_valid_reg;
    assign dn_data  = b_reg;

    assign em           = SECTOR_M - up_data.m;
    assign a_valid_next = up_valid;

    always_comb
    begin
        a_next.sector = up_data.sector;
        a_next.v      = up_data.v;
        a_next.s_inv  = LEVEL_MAX - up_data.s;
        a_next.sm     = {7'd0, up_data.s} * {8'd0, up_data.m};
        a_next.st     = {7'd0, up_data.s} * {8'd0, em};
    end

    // stage b: value products and 2n + den
    assign qd           = FULL_DEN - a_reg.sm;
    assign td           = FULL_DEN - a_reg.st;
    assign qn           = {15'd0, a_reg.v} * {8'd0, qd};
    assign tn           = {15'd0, a_reg.v} * {8'd0, td};
    assign pn           = {8'd0, a_reg.v} * {8'd0, a_reg.s_inv};
    assign b_valid_next = a_valid_reg;

    always_comb
    begin
        b_next.sector = a_reg.sector;
        b_next.v      = a_reg.v;
        b_next.xp     = {pn, 1'b0} + {9'd0, LEVEL_MAX};
        b_next.xq     = {qn, 1'b0} + {9'd0, FULL_DEN};
        b_next.xt     = {tn, 1'b0} + {9'd0, FULL_DEN};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= a_valid_next;
            end
            if (b_en)
            begin
                b_valid_reg <= b_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && up_valid)
        begin
            a_reg <= a_next;
        end
        if (b_en && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hsvbgr_round.sv -----
// ----------------------------------------------------------------------------
// hsvbgr_round
// constant division by reciprocal, one-step correction and sector routing
// ----------------------------------------------------------------------------
`default_nettype none

module hsvbgr_round
    import hsvbgr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   up_valid,
    output logic        up_stall,
    input  wire numer_t up_data,
    output logic        dn_valid,
    input  wire logic   dn_stall,
    output bgr_t        dn_data
);

    logic   a_valid_reg;
    logic   a_valid_next;
    estim_t a_reg;
    estim_t a_next;
    logic   a_en;
    logic   b_valid_reg;
    logic   b_valid_next;
    bgr_t   b_reg;
    bgr_t   b_next;
    logic   b_en;
    logic [24:0] prod_p;
    logic [32:0] prod_q;
    logic [32:0] prod_t;
    logic [8:0]  hp;
    logic [8:0]  hq;
    logic [8:0]  ht;
    logic [17:0] chk_p;
    logic [24:0] chk_q;
    logic [24:0] chk_t;
    logic [7:0]  p;
    logic [7:0]  q;
    logic [7:0]  t;

    assign b_en     = !b_valid_reg || !dn_stall;
    assign a_en     = !a_valid_reg || b_en;
    assign up_stall = !a_en;
    assign dn_valid = b_valid_reg;
    assign dn_data  = b_reg;

    // stage a: estimates, low by at most one
    assign prod_p       = {8'd0, up_data.xp} * {16'd0, P_RECIP};
    assign prod_q       = {9'd0, up_data.xq} * {24'd0, Q_RECIP};
    assign prod_t       = {9'd0, up_data.xt} * {24'd0, Q_RECIP};
    assign a_valid_next = up_valid;

    always_comb
    begin
        a_next.sector = up_data.sector;
        a_next.v      = up_data.v;
        a_next.xp     = up_data.xp;
        a_next.xq     = up_data.xq;
        a_next.xt     = up_data.xt;
        a_next.ep     = prod_p[24:17];
        a_next.eq     = prod_q[31:24];
        a_next.et     = prod_t[31:24];
    end

    // stage b: correction and routing
    assign hp    = {1'b0, a_reg.ep} + 9'd1;
    assign hq    = {1'b0, a_reg.eq} + 9'd1;
    assign ht    = {1'b0, a_reg.et} + 9'd1;
    assign chk_p = {9'd0, hp} * {8'd0, P_DIV2};
    assign chk_q = {16'd0, hq} * {9'd0, Q_DIV2};
    assign chk_t = {16'd0, ht} * {9'd0, Q_DIV2};
    assign p     = ({1'b0, a_reg.xp} >= chk_p) ? hp[7:0] : a_reg.ep;
    assign q     = ({1'b0, a_reg.xq} >= chk_q) ? hq[7:0] : a_reg.eq;
    assign t     = ({1'b0, a_reg.xt} >= chk_t) ? ht[7:0] : a_reg.et;

    assign b_valid_next = a_valid_reg;

    always_comb
    begin
        case (a_reg.sector)
            SEC_1:
            begin
                b_next = '{blue_out: p, green_out: a_reg.v, red_out: q};
            end
            SEC_2:
            begin
                b_next = '{blue_out: t, green_out: a_reg.v, red_out: p};
            end
            SEC_3:
            begin
                b_next = '{blue_out: a_reg.v, green_out: q, red_out: p};
            end
            SEC_4:
            begin
                b_next = '{blue_out: a_reg.v, green_out: p, red_out: t};
            end
            SEC_5:
            begin
                b_next = '{blue_out: q, green_out: p, red_out: a_reg.v};
            end
            default:
            begin
                b_next = '{blue_out: p, green_out: t, red_out: a_reg.v};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= a_valid_next;
            end
            if (b_en)
            begin
                b_valid_reg <= b_valid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en && up_valid)
        begin
            a_reg <= a_next;
        end
        if (b_en && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/hsv_to_bgr_pixel_converter_core.sv -----
// the path from input transfer to output valid has one register per stage
// throughput: one pixel per cycle while the output does not stall; stages: clamp/sector,
// s products, v products, reciprocal estimate, correction and routing
// each stage holds while its successor is full and stalled, bubbles are squeezed
// reset clears every stage valid bit; payload registers are not reset
// ----------------------------------------------------------------------------
// hsv_to_bgr_pixel_converter_core
// five stage hsv to bgr pixel converter with 8-bit hue circle
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_bgr_pixel_converter_core
    import hsvbgr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic hsv_valid,
    output logic      hsv_stall,
    input  wire hsv_t hsv,
    output logic      bgr_valid,
    input  wire logic bgr_stall,
    output bgr_t      bgr
);

    logic   s1_valid;
    logic   s1_stall;
    split_t s1_data;
    logic   s3_valid;
    logic   s3_stall;
    numer_t s3_data;

    hsvbgr_sector u_sector (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (hsv_valid),
        .up_stall (hsv_stall),
        .up_data  (hsv),
        .dn_valid (s1_valid),
        .dn_stall (s1_stall),
        .dn_data  (s1_data)
    );

    hsvbgr_product u_product (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_stall (s1_stall),
        .up_data  (s1_data),
        .dn_valid (s3_valid),
        .dn_stall (s3_stall),
        .dn_data  (s3_data)
    );

    hsvbgr_round u_round (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_stall (s3_stall),
        .up_data  (s3_data),
        .dn_valid (bgr_valid),
        .dn_stall (bgr_stall),
        .dn_data  (bgr)
    );

    // an empty output stage lets the whole pipe move
    a_no_stall_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !bgr_valid |-> !hsv_stall
    ) else $error("input stalled while output stage empty");

    // a stall at the input needs every stage to be full
    a_stall_needs_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        hsv_stall |-> (s1_valid && s3_valid && bgr_valid && bgr_stall)
    ) else $error("input stalled with a bubble in the pipe");

    // a middle stage that is full and stalled behind a stalled output keeps its item
    a_stall_propagates: assert property (
        @(posedge clk) disable iff (!rst_n)
        (bgr_valid && bgr_stall && s3_valid && s3_stall) |=> s3_valid
    ) else $error("middle stage lost an item under stall");

endmodule

`default_nettype wire

// ----- tb/hsv_to_bgr_pixel_converter_core_test.sv -----
// ----------------------------------------------------------------------------
// hsv_to_bgr_pixel_converter_core_test
// drives pixels through the hsv to bgr converter and compares each output
// pixel with a bit-exact value, typed in the table or computed here. a directed
// table covers clamping, the extremes, the hue wrap at 255 and the sector edges;
// random pixels follow, with random gaps on the input side and random stalls
// on the output side, broken up by stretches without either.
// ----------------------------------------------------------------------------
module hsv_to_bgr_pixel_converter_core_test;
    import hsvbgr_pkg::*;

    localparam int NUM_DIR      = 22;
    localparam int NUM_RAND     = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MODE_SPAN    = 50;

    typedef struct packed {
        hsv_t px;
        logic typed;
        bgr_t want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic hsv_valid = 1'b0;
    logic hsv_stall;
    hsv_t hsv       = '0;
    logic bgr_valid;
    logic bgr_stall = 1'b0;
    bgr_t bgr;

    bgr_t        pending_bgr [$];
    bgr_t        next_bgr;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int unsigned stall_left     = 0;
    int unsigned bgr_seen       = 0;
    bit          send_idle      = 1'b1;
    bit          recv_idle      = 1'b1;

    hsv_to_bgr_pixel_converter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_stall (hsv_stall),
        .hsv       (hsv),
        .bgr_valid (bgr_valid),
        .bgr_stall (bgr_stall),
        .bgr       (bgr)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned clamp_level(input logic signed [15:0] x);
        if (x < 0)
            return 0;
        if (x > 255)
            return 255;
        return int'(x);
    endfunction

    function automatic int unsigned round_div(input int unsigned num, input int unsigned den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic bgr_t convert_pixel(input hsv_t px);
        int unsigned h, s, v, hh, m, p, q, t, full;
        logic [2:0]  sector;
        bgr_t        res;
        h      = clamp_level(px.hue_in);
        s      = clamp_level(px.sat_in);
        v      = clamp_level(px.val_in);
        full   = int'(FULL_DEN);
        hh     = 2 * h;
        sector = 3'(hh / int'(SECTOR_M));
        m      = hh % int'(SECTOR_M);
        p      = round_div(v * (255 - s), 255);
        q      = round_div(v * (full - s * m), full);
        t      = round_div(v * (full - s * (int'(SECTOR_M) - m)), full);
        // hue 255 lands in sector 6 and is routed as sector 0
        case (sector)
            SEC_1:   res = {8'(p), 8'(v), 8'(q)};
            SEC_2:   res = {8'(t), 8'(v), 8'(p)};
            SEC_3:   res = {8'(v), 8'(q), 8'(p)};
            SEC_4:   res = {8'(v), 8'(p), 8'(t)};
            SEC_5:   res = {8'(q), 8'(p), 8'(v)};
            default: res = {8'(p), 8'(t), 8'(v)};
        endcase
        return res;
    endfunction

    function automatic dir_row_t dir_row(input int idx);
        dir_row_t r;
        case (idx)
            0:  r = {16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0,   8'd0,   8'd0};
            1:  r = {16'h0000, 16'h00FF, 16'h00FF, 1'b1, 8'd0,   8'd0,   8'd255};
            2:  r = {16'h8000, 16'h8000, 16'h7FFF, 1'b1, 8'd255, 8'd255, 8'd255};
            3:  r = {16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 8'd0,   8'd0,   8'd255};
            4:  r = {16'h00FF, 16'h0000, 16'h00FF, 1'b1, 8'd255, 8'd255, 8'd255};
            5:  r = {16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'd0,   8'd0,   8'd0};
            6:  r = {16'h0100, 16'h0100, 16'h0100, 1'b1, 8'd0,   8'd0,   8'd255};
            7:  r = {16'h00FF, 16'h00FF, 16'h0080, 1'b0, 24'h0};
            8:  r = {16'd42,   16'h00FF, 16'h00FF, 1'b0, 24'h0};
            9:  r = {16'd43,   16'h00FF, 16'h00FF, 1'b0, 24'h0};
            10: r = {16'd64,   16'd200,  16'd100,  1'b0, 24'h0};
            11: r = {16'd85,   16'h00FF, 16'h00FF, 1'b0, 24'h0};
            12: r = {16'd127,  16'd100,  16'd200,  1'b0, 24'h0};
            13: r = {16'd128,  16'h00FF, 16'h00FF, 1'b0, 24'h0};
            14: r = {16'd170,  16'h00FF, 16'h00FF, 1'b0, 24'h0};
            15: r = {16'd212,  16'h00FF, 16'h00FF, 1'b0, 24'h0};
            16: r = {16'd213,  16'h00FF, 16'h00FF, 1'b0, 24'h0};
            17: r = {16'd254,  16'h00FF, 16'h00FF, 1'b0, 24'h0};
            18: r = {16'h5555, 16'hAAAA, 16'h00FF, 1'b0, 24'h0};
            19: r = {16'd1,    16'd1,    16'd1,    1'b0, 24'h0};
            20: r = {16'h0100, 16'h00FF, 16'h0080, 1'b0, 24'h0};
            default: r = {16'd30, 16'd128, 16'h7F80, 1'b0, 24'h0};
        endcase
        return r;
    endfunction

    function automatic int unsigned draw_wait(input bit idle_on);
        return idle_on ? $urandom_range(0, 10) : 0;
    endfunction

    function automatic logic signed [15:0] rand_field();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            return 16'($urandom);
        if (kind == 1)
        begin
            case ($urandom_range(0, 5))
                0:       return 16'hFFFF;
                1:       return 16'h0000;
                2:       return 16'h00FF;
                3:       return 16'h0100;
                4:       return 16'h7FFF;
                default: return 16'h8000;
            endcase
        end
        return 16'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input hsv_t px, input bgr_t want);
        int unsigned gap;
        gap = draw_wait(send_idle);
        if (gap != 0)
        begin
            hsv_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        hsv       <= px;
        next_bgr   = want;
        hsv_valid <= 1'b1;
        @(posedge clk);
        while (hsv_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // output stall, drawn afresh after each output transfer
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            bgr_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            bgr_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        bgr_t want;
        if (rst_n)
        begin
            if (hsv_valid && !hsv_stall)
                pending_bgr.push_back(next_bgr);
            if (bgr_valid && !bgr_stall)
            begin
                if (pending_bgr.size() == 0)
                begin
                    $display("%0t: unexpected pixel %h", $time, bgr);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_bgr.pop_front();
                    report_field("blue",  want.blue_out,  bgr.blue_out);
                    report_field("green", want.green_out, bgr.green_out);
                    report_field("red",   want.red_out,   bgr.red_out);
                end
                bgr_seen++;
                if (bgr_seen % MODE_SPAN == 0)
                    recv_idle = ($urandom_range(0, 3) != 0);
                stall_left = draw_wait(recv_idle);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        dir_row_t row;
        hsv_t     px;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int i = 0; i < NUM_DIR; i++)
        begin
            row = dir_row(i);
            send_pixel(row.px, row.typed ? row.want : convert_pixel(row.px));
        end
        for (int i = 0; i < NUM_RAND; i++)
        begin
            if (i % MODE_SPAN == 0)
                send_idle = ($urandom_range(0, 3) != 0);
            px.hue_in = rand_field();
            px.sat_in = rand_field();
            px.val_in = rand_field();
            send_pixel(px, convert_pixel(px));
        end
        hsv_valid <= 1'b0;
        while (pending_bgr.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
